FILE: hdl/otpg_pkg.sv
// Shared types and constants for the one-time PIN gate.
package otpg_pkg;

  typedef enum logic [1:0] {
    CMD_GENERATE = 2'd0,
    CMD_VALIDATE = 2'd1,
    CMD_RESET    = 2'd2,
    CMD_QUERY    = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    RC_ISSUED       = 4'd0,
    RC_REFUSED      = 4'd1,
    RC_OK           = 4'd2,
    RC_MISMATCH     = 4'd3,
    RC_NO_ACTIVE    = 4'd4,
    RC_EXPIRED      = 4'd5,
    RC_RATE_LIMITED = 4'd6,
    RC_CLEARED      = 4'd7,
    RC_STATUS       = 4'd8
  } rc_t;

  localparam logic [1:0] CFG_EXPIRY    = 2'd0;
  localparam logic [1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [1:0] CFG_DURATION  = 2'd2;

  localparam logic [30:0] EXPIRY_RST    = 31'd300000;
  localparam logic [7:0]  THRESHOLD_RST = 8'd5;
  localparam logic [30:0] DURATION_RST  = 31'd60000;

  localparam logic [19:0] PIN_MODULUS = 20'd1000000;
  // floor(2^32 / modulus); the quotient estimate is then low by at most one.
  localparam logic [12:0] PIN_RECIP = 13'((64'd1 << 32) / 64'(PIN_MODULUS));

  typedef struct packed {
    logic [30:0] expiry_ms;
    logic [7:0]  lockout_threshold;
    logic [30:0] lockout_duration_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] now_ms;
    logic [19:0] candidate;
    logic [31:0] random_word;
  } req_t;

  // Request plus the random word reduced to below twice the modulus.
  typedef struct packed {
    req_t        req;
    logic [20:0] rem_raw;
  } red_t;

  typedef struct packed {
    rc_t         result_code;
    logic        pin_active;
    logic        locked_out;
    logic [30:0] lockout_remaining_ms;
    logic [30:0] pin_remaining_ms;
    logic [19:0] pin_value;
    logic        show_pin_request;
  } rsp_t;

endpackage

FILE: hdl/otpg_if.sv
// Request and response channel interfaces of the one-time PIN gate.
interface otpg_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] now_ms;
  logic [19:0] candidate;
  logic [31:0] random_word;

  modport source (output valid, command, now_ms, candidate, random_word, input ready);
  modport sink (input valid, command, now_ms, candidate, random_word, output ready);
endinterface

interface otpg_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  result_code;
  logic        pin_active;
  logic        locked_out;
  logic [30:0] lockout_remaining_ms;
  logic [30:0] pin_remaining_ms;
  logic [19:0] pin_value;
  logic        show_pin_request;

  modport source (output valid, result_code, pin_active, locked_out, lockout_remaining_ms,
                  pin_remaining_ms, pin_value, show_pin_request, input ready);
  modport sink (input valid, result_code, pin_active, locked_out, lockout_remaining_ms,
                pin_remaining_ms, pin_value, show_pin_request, output ready);
endinterface

FILE: hdl/otpg_pin_reduce.sv
// Three-stage front pipeline that reduces the random word to below twice the PIN modulus.
module otpg_pin_reduce
  import otpg_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  req_t in_item,
  output logic in_ready,
  output logic out_valid,
  output red_t out_item,
  input  logic out_ready
);

  logic        v1;
  logic        v2;
  logic        v3;
  req_t        s1;
  req_t        s2;
  logic [12:0] q2;
  red_t        s3;
  logic        en1;
  logic        en2;
  logic        en3;
  logic [44:0] q_prod;
  logic [32:0] m_prod;
  logic [31:0] rem_full;

  // Each stage takes a new item when it is empty or its item moves on.
  assign en3 = !v3 || out_ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;

  assign q_prod   = {13'd0, s1.random_word} * {32'd0, PIN_RECIP};
  assign m_prod   = {20'd0, q2} * {13'd0, PIN_MODULUS};
  assign rem_full = s2.random_word - m_prod[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= in_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      s1 <= in_item;
    end
    if (en2 && v1) begin
      s2 <= s1;
      q2 <= q_prod[44:32];
    end
    if (en3 && v2) begin
      s3.req     <= s2;
      s3.rem_raw <= rem_full[20:0];
    end
  end

  assign out_valid = v3;
  assign out_item  = s3;

endmodule

FILE: hdl/otpg_core.sv
// Gate state, command decode and the registered response.
module otpg_core
  import otpg_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic in_valid,
  input  red_t in_item,
  output logic in_ready,
  output logic out_valid,
  output rsp_t out_item,
  input  logic out_ready
);

  logic [19:0] stored_pin;
  logic [31:0] expiry_time;
  logic        attempt_left;
  logic [7:0]  mismatch_count;
  logic [31:0] lockout_end_time;
  logic        show_flag;

  logic [19:0] stored_pin_next;
  logic [31:0] expiry_time_next;
  logic        attempt_left_next;
  logic [7:0]  mismatch_count_next;
  logic [31:0] lockout_end_time_next;
  logic        show_flag_next;
  rsp_t        rsp_next;

  cmd_t        cmd;
  logic [31:0] now;
  logic [20:0] rem_fix;
  logic [19:0] pin_mod;
  logic [31:0] d_lock;
  logic [31:0] d_exp;
  logic        lock_run;
  logic        exp_run;
  logic        held;
  logic [7:0]  mm_count;
  logic [31:0] lock_sum;
  logic [31:0] lock_end_new;
  logic [31:0] d_lock_new;
  logic        start_lock;
  logic        gen;
  rc_t         code;
  logic [31:0] lrem;
  logic        lrem_ok;
  logic [31:0] d_pin;
  logic        prem_ok;
  logic        take;

  assign cmd = cmd_t'(in_item.req.command);
  assign now = in_item.req.now_ms;

  assign rem_fix = in_item.rem_raw - {1'b0, PIN_MODULUS};
  assign pin_mod = (in_item.rem_raw >= {1'b0, PIN_MODULUS}) ? rem_fix[19:0]
                                                             : in_item.rem_raw[19:0];

  // A target lies ahead when target minus now is positive as a signed word.
  assign d_lock   = lockout_end_time - now;
  assign d_exp    = expiry_time - now;
  assign lock_run = (lockout_end_time != 32'd0) && (d_lock != 32'd0) && !d_lock[31];
  assign exp_run  = (d_exp != 32'd0) && !d_exp[31];
  assign held     = (stored_pin != 20'd0) && attempt_left;
  assign mm_count = mismatch_count + 8'd1;

  // An end time of zero would read as no lockout, so it is stored as one.
  assign lock_sum     = now + {1'b0, cfg.lockout_duration_ms};
  assign lock_end_new = (lock_sum == 32'd0) ? 32'd1 : lock_sum;
  assign d_lock_new   = (lock_sum == 32'd0) ? (32'd1 - now) : {1'b0, cfg.lockout_duration_ms};

  always_comb begin
    stored_pin_next     = stored_pin;
    expiry_time_next    = expiry_time;
    attempt_left_next   = attempt_left;
    mismatch_count_next = mismatch_count;
    show_flag_next      = show_flag;
    lockout_end_time_next = lock_run ? lockout_end_time : 32'd0;
    start_lock = 1'b0;
    gen        = 1'b0;
    code       = RC_STATUS;
    case (cmd)
      CMD_GENERATE: begin
        if (lock_run) begin
          code = RC_REFUSED;
        end else begin
          stored_pin_next   = pin_mod;
          expiry_time_next  = now + {1'b0, cfg.expiry_ms};
          attempt_left_next = 1'b1;
          show_flag_next    = 1'b1;
          gen  = 1'b1;
          code = RC_ISSUED;
        end
      end
      CMD_VALIDATE: begin
        if (lock_run) begin
          code = RC_RATE_LIMITED;
        end else if (!held) begin
          code = RC_NO_ACTIVE;
        end else if (!exp_run) begin
          stored_pin_next   = 20'd0;
          attempt_left_next = 1'b0;
          code = RC_EXPIRED;
        end else if (in_item.req.candidate == stored_pin) begin
          stored_pin_next     = 20'd0;
          attempt_left_next   = 1'b0;
          mismatch_count_next = 8'd0;
          code = RC_OK;
        end else if (mm_count >= cfg.lockout_threshold) begin
          stored_pin_next       = 20'd0;
          attempt_left_next     = 1'b0;
          mismatch_count_next   = 8'd0;
          lockout_end_time_next = lock_end_new;
          start_lock = 1'b1;
          code = RC_RATE_LIMITED;
        end else begin
          mismatch_count_next = mm_count;
          code = RC_MISMATCH;
        end
      end
      CMD_RESET: begin
        stored_pin_next       = 20'd0;
        expiry_time_next      = 32'd0;
        attempt_left_next     = 1'b0;
        mismatch_count_next   = 8'd0;
        lockout_end_time_next = 32'd0;
        show_flag_next        = 1'b0;
        code = RC_CLEARED;
      end
      default: begin
        code = RC_STATUS;
      end
    endcase
  end

  // Remaining lockout after the command; a fresh window that is already over clears itself.
  always_comb begin
    if (start_lock) begin
      lrem = d_lock_new;
    end else if (lockout_end_time_next != 32'd0) begin
      lrem = d_lock;
    end else begin
      lrem = 32'd0;
    end
    lrem_ok = (lrem != 32'd0) && !lrem[31];
    d_pin   = gen ? {1'b0, cfg.expiry_ms} : d_exp;
    prem_ok = (stored_pin_next != 20'd0) && attempt_left_next && (d_pin != 32'd0) && !d_pin[31];
  end

  always_comb begin
    rsp_next.result_code          = code;
    rsp_next.locked_out           = lrem_ok;
    rsp_next.pin_active           = !lrem_ok && prem_ok;
    rsp_next.lockout_remaining_ms = lrem_ok ? lrem[30:0] : 31'd0;
    rsp_next.pin_remaining_ms     = prem_ok ? d_pin[30:0] : 31'd0;
    rsp_next.pin_value            = stored_pin_next;
    rsp_next.show_pin_request     = show_flag_next;
  end

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_pin       <= 20'd0;
      expiry_time      <= 32'd0;
      attempt_left     <= 1'b0;
      mismatch_count   <= 8'd0;
      lockout_end_time <= 32'd0;
      show_flag        <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (take) begin
        stored_pin       <= stored_pin_next;
        expiry_time      <= expiry_time_next;
        attempt_left     <= attempt_left_next;
        mismatch_count   <= mismatch_count_next;
        lockout_end_time <= lrem_ok ? lockout_end_time_next : 32'd0;
        show_flag        <= show_flag_next;
      end
      if (in_ready) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item <= rsp_next;
    end
  end

endmodule

FILE: hdl/one_time_pin_gate_with_lockout.sv
// Top level of the one-time PIN gate with mismatch lockout.
// Each result is registered after the three reduction stages and the state stage.
// Throughput: one item per cycle unless rsp.ready stalls; the stages are fully pipelined.
// The state stage updates the PIN state as it takes each item, so back-to-back commands see fresh state.
// Synchronous reset clears the PIN state, the pipeline and loads the register defaults.
module one_time_pin_gate_with_lockout
  import otpg_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  otpg_req_if.sink    req,
  otpg_rsp_if.source  rsp
);

  cfg_t cfg;
  req_t req_item;
  red_t red_item;
  logic red_valid;
  logic red_ready;
  rsp_t rsp_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expiry_ms           <= EXPIRY_RST;
      cfg.lockout_threshold   <= THRESHOLD_RST;
      cfg.lockout_duration_ms <= DURATION_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_EXPIRY:    cfg.expiry_ms           <= cfg_data;
        CFG_THRESHOLD: cfg.lockout_threshold   <= cfg_data[7:0];
        CFG_DURATION:  cfg.lockout_duration_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    req_item.command     = req.command;
    req_item.now_ms      = req.now_ms;
    req_item.candidate   = req.candidate;
    req_item.random_word = req.random_word;
  end

  otpg_pin_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_item   (req_item),
    .in_ready  (req.ready),
    .out_valid (red_valid),
    .out_item  (red_item),
    .out_ready (red_ready)
  );

  otpg_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (red_valid),
    .in_item   (red_item),
    .in_ready  (red_ready),
    .out_valid (rsp.valid),
    .out_item  (rsp_item),
    .out_ready (rsp.ready)
  );

  assign rsp.result_code          = rsp_item.result_code;
  assign rsp.pin_active           = rsp_item.pin_active;
  assign rsp.locked_out           = rsp_item.locked_out;
  assign rsp.lockout_remaining_ms = rsp_item.lockout_remaining_ms;
  assign rsp.pin_remaining_ms     = rsp_item.pin_remaining_ms;
  assign rsp.pin_value            = rsp_item.pin_value;
  assign rsp.show_pin_request     = rsp_item.show_pin_request;

endmodule

FILE: hdl/otpg_checker.sv
// Port-level checks of the PIN gate and the bind that attaches them.
module otpg_checker
  import otpg_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [3:0]  result_code,
  input logic        pin_active,
  input logic        locked_out,
  input logic [30:0] lockout_remaining_ms,
  input logic [19:0] pin_value,
  input logic        show_pin_request
);

  a_active_not_locked: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(pin_active && locked_out))
    else $error("active PIN reported during lockout");

  a_lock_time: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (locked_out == (lockout_remaining_ms != 31'd0)))
    else $error("lockout flag and remaining time disagree");

  a_cleared: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && result_code == RC_CLEARED) |->
      (pin_value == 20'd0 && !show_pin_request && !locked_out && !pin_active))
    else $error("reset command left state behind");

  a_issued_show: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && result_code == RC_ISSUED) |-> (show_pin_request && !locked_out))
    else $error("issued PIN without show request or while locked");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(result_code)))
    else $error("stalled result changed");

endmodule

bind one_time_pin_gate_with_lockout otpg_checker u_checker (
  .clk                  (clk),
  .rst                  (rst),
  .rsp_valid            (rsp.valid),
  .rsp_ready            (rsp.ready),
  .result_code          (rsp.result_code),
  .pin_active           (rsp.pin_active),
  .locked_out           (rsp.locked_out),
  .lockout_remaining_ms (rsp.lockout_remaining_ms),
  .pin_value            (rsp.pin_value),
  .show_pin_request     (rsp.show_pin_request)
);

FILE: tb/sv/testbench.sv
// Self-checking testbench for the one-time PIN gate with mismatch lockout.
module testbench;
  import otpg_pkg::*;

  // The register port decodes two bits; this index names no register.
  localparam logic [1:0] CFG_SPARE = 2'd3;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [30:0] cfg_data;

  otpg_req_if req_ch ();
  otpg_rsp_if rsp_ch ();

  one_time_pin_gate_with_lockout u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Shadow copy of the gate state and its registers.
  logic [19:0] m_pin;
  logic [31:0] m_expiry_at;
  logic        m_armed;
  logic [7:0]  m_misses;
  logic [31:0] m_lock_end;
  logic        m_show;
  logic [30:0] m_expiry_ms;
  logic [7:0]  m_threshold;
  logic [30:0] m_lock_ms;

  rsp_t        verdicts_due [$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_order = 0;
  int unsigned failures = 0;
  int unsigned checked = 0;
  int unsigned sent = 0;
  int unsigned settings_applied = 0;
  int unsigned rc_tally [0:8];
  logic [31:0] clock_ms = 32'd0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic req_t make_req(cmd_t c, logic [31:0] now, logic [19:0] cand,
                                    logic [31:0] rnd);
    req_t r;
    r.command     = c;
    r.now_ms      = now;
    r.candidate   = cand;
    r.random_word = rnd;
    return r;
  endfunction

  // Time left until target, zero once the signed difference is no longer positive.
  function automatic logic [31:0] ms_until(logic [31:0] target, logic [31:0] now);
    logic [31:0] d;
    d = target - now;
    return (d == 32'd0 || d[31]) ? 32'd0 : d;
  endfunction

  // A lockout that has run out clears itself whenever it is looked at.
  function automatic logic [31:0] lock_ms_left(logic [31:0] now);
    logic [31:0] left;
    left = 32'd0;
    if (m_lock_end != 32'd0) begin
      left = ms_until(m_lock_end, now);
      if (left == 32'd0) m_lock_end = 32'd0;
    end
    return left;
  endfunction

  function automatic void forget_pin_state();
    m_pin       = 20'd0;
    m_expiry_at = 32'd0;
    m_armed     = 1'b0;
    m_misses    = 8'd0;
    m_lock_end  = 32'd0;
    m_show      = 1'b0;
  endfunction

  function automatic rsp_t predict_verdict(req_t r);
    rsp_t        v;
    rc_t         code;
    logic        locked;
    logic [31:0] lrem;
    logic [31:0] prem;
    locked = lock_ms_left(r.now_ms) != 32'd0;
    case (r.command)
      CMD_GENERATE: begin
        if (locked) begin
          code = RC_REFUSED;
        end else begin
          m_pin       = 20'(r.random_word % PIN_MODULUS);
          m_expiry_at = r.now_ms + {1'b0, m_expiry_ms};
          m_armed     = 1'b1;
          m_show      = 1'b1;
          code        = RC_ISSUED;
        end
      end
      CMD_VALIDATE: begin
        if (locked) begin
          code = RC_RATE_LIMITED;
        end else if (m_pin == 20'd0 || !m_armed) begin
          code = RC_NO_ACTIVE;
        end else if (ms_until(m_expiry_at, r.now_ms) == 32'd0) begin
          m_pin   = 20'd0;
          m_armed = 1'b0;
          code    = RC_EXPIRED;
        end else if (r.candidate == m_pin) begin
          m_pin    = 20'd0;
          m_armed  = 1'b0;
          m_misses = 8'd0;
          code     = RC_OK;
        end else begin
          m_misses = m_misses + 8'd1;
          if (m_misses >= m_threshold) begin
            m_pin      = 20'd0;
            m_armed    = 1'b0;
            m_lock_end = r.now_ms + {1'b0, m_lock_ms};
            // An end time of zero would read as no lockout at all.
            if (m_lock_end == 32'd0) m_lock_end = 32'd1;
            m_misses   = 8'd0;
            code       = RC_RATE_LIMITED;
          end else begin
            code = RC_MISMATCH;
          end
        end
      end
      CMD_RESET: begin
        forget_pin_state();
        code = RC_CLEARED;
      end
      default: begin
        code = RC_STATUS;
      end
    endcase
    lrem = lock_ms_left(r.now_ms);
    prem = (m_pin != 20'd0 && m_armed) ? ms_until(m_expiry_at, r.now_ms) : 32'd0;
    v.result_code          = code;
    v.pin_active           = (lrem == 32'd0) && (prem != 32'd0);
    v.locked_out           = lrem != 32'd0;
    v.lockout_remaining_ms = lrem[30:0];
    v.pin_remaining_ms     = prem[30:0];
    v.pin_value            = m_pin;
    v.show_pin_request     = m_show;
    rc_tally[code]++;
    return v;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  task automatic check_verdict();
    rsp_t want;
    if (verdicts_due.size() == 0) begin
      $error("result arrived with no request outstanding");
      failures++;
      return;
    end
    want = verdicts_due.pop_front();
    compare_field("result_code", want.result_code, rsp_ch.result_code);
    compare_field("pin_active", want.pin_active, rsp_ch.pin_active);
    compare_field("locked_out", want.locked_out, rsp_ch.locked_out);
    compare_field("lockout_remaining_ms", want.lockout_remaining_ms,
                  rsp_ch.lockout_remaining_ms);
    compare_field("pin_remaining_ms", want.pin_remaining_ms, rsp_ch.pin_remaining_ms);
    compare_field("pin_value", want.pin_value, rsp_ch.pin_value);
    compare_field("show_pin_request", want.show_pin_request, rsp_ch.show_pin_request);
    checked++;
  endtask

  // Result side: checks each accepted item and decides ready for the next edge.
  initial begin : rsp_sink
    int unsigned hold_left;
    hold_left = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) check_verdict();
      if (hold_order != 0) begin
        hold_left  = hold_order;
        hold_order = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Called at a rising edge; returns at the edge where the item was taken, with
  // valid still high so that a following item can go out without a gap.
  task automatic offer_request(input req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.command     <= r.command;
    req_ch.now_ms      <= r.now_ms;
    req_ch.candidate   <= r.candidate;
    req_ch.random_word <= r.random_word;
    do @(posedge clk); while (!req_ch.ready);
    verdicts_due.push_back(predict_verdict(r));
    sent++;
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [30:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Loads all three registers, plus a write to the unused index that must be ignored.
  task automatic apply_settings(input logic [30:0] life, input logic [7:0] thr,
                                input logic [30:0] lock);
    settle();
    write_reg(CFG_EXPIRY, life);
    write_reg(CFG_THRESHOLD, {23'($urandom()), thr});
    write_reg(CFG_DURATION, lock);
    write_reg(CFG_SPARE, 31'($urandom()));
    cfg_write <= 1'b0;
    m_expiry_ms = life;
    m_threshold = thr;
    m_lock_ms   = lock;
    settings_applied++;
  endtask

  task automatic set_idle(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Mostly plausible sessions: issue a PIN, then try it, with time mostly moving forward.
  function automatic req_t next_session_request(int unsigned span);
    int unsigned roll;
    logic        held;
    cmd_t        c;
    logic [19:0] cand;
    logic [31:0] rnd;
    roll = $urandom_range(0, 99);
    if (roll < 3) clock_ms = $urandom();
    else if (roll < 12) clock_ms = clock_ms + $urandom_range(0, 4 * span);
    else clock_ms = clock_ms + $urandom_range(0, span / 4);
    held = (m_pin != 20'd0) && m_armed;
    roll = $urandom_range(0, 99);
    if (roll < 2) c = CMD_RESET;
    else if (roll < 14) c = CMD_QUERY;
    else if (held ? (roll < 24) : (roll < 70)) c = CMD_GENERATE;
    else c = CMD_VALIDATE;
    if (held && $urandom_range(0, 3) == 0) cand = m_pin;
    else cand = 20'($urandom_range(0, 999999));
    if ($urandom_range(0, 9) == 0) rnd = $urandom_range(0, 4294) * 1000000 + $urandom_range(0, 1);
    else rnd = $urandom();
    return make_req(c, clock_ms, cand, rnd);
  endfunction

  task automatic test_directed_sequences();
    offer_request(make_req(CMD_QUERY, 32'd0, 20'd0, 32'd0));
    offer_request(make_req(CMD_VALIDATE, 32'd10, 20'd0, 32'd0));
    offer_request(make_req(CMD_GENERATE, 32'd100, 20'd0, 32'hFFFFFFFF));
    offer_request(make_req(CMD_VALIDATE, 32'd200, 20'd967295, 32'd0));
    offer_request(make_req(CMD_VALIDATE, 32'd300, 20'd967295, 32'd0));
    // A random word that reduces to zero issues a PIN that counts as none.
    offer_request(make_req(CMD_GENERATE, 32'd400, 20'd0, 32'd0));
    offer_request(make_req(CMD_VALIDATE, 32'd500, 20'd0, 32'd0));
    // Expiry wraps past the top of the time range and is hit exactly.
    offer_request(make_req(CMD_GENERATE, 32'hFFFFFF00, 20'd0, 32'd123456789));
    offer_request(make_req(CMD_QUERY, 32'd0, 20'd0, 32'd0));
    offer_request(make_req(CMD_VALIDATE, 32'hFFFFFF00 + 32'd300000, 20'd456789, 32'd0));
    offer_request(make_req(CMD_GENERATE, 32'd1000, 20'd0, 32'd999999));
    offer_request(make_req(CMD_VALIDATE, 32'd2000, 20'd0, 32'd0));
    offer_request(make_req(CMD_VALIDATE, 32'd3000, 20'd999998, 32'd0));
    offer_request(make_req(CMD_VALIDATE, 32'd4000, 20'd1, 32'd0));
    offer_request(make_req(CMD_VALIDATE, 32'd5000, 20'd524288, 32'd0));
    // The fifth miss lands where the lockout end would compute to zero.
    offer_request(make_req(CMD_VALIDATE, 32'hFFFF15A0, 20'd7, 32'd0));
    offer_request(make_req(CMD_GENERATE, 32'd0, 20'd0, 32'd55));
    offer_request(make_req(CMD_VALIDATE, 32'd0, 20'd0, 32'd0));
    offer_request(make_req(CMD_QUERY, 32'd1, 20'd0, 32'd0));
    offer_request(make_req(CMD_GENERATE, 32'd2, 20'd0, 32'd1000001));
    offer_request(make_req(CMD_VALIDATE, 32'hFFFFFFFF, 20'd999999, 32'd0));
    offer_request(make_req(CMD_RESET, 32'd3, 20'd0, 32'd0));
    offer_request(make_req(CMD_QUERY, 32'h80000000, 20'd0, 32'd0));
    settle();
  endtask

  task automatic test_register_corners();
    apply_settings(31'h7FFFFFFF, 8'd1, 31'h7FFFFFFF);
    offer_request(make_req(CMD_GENERATE, 32'd0, 20'd0, 32'd777));
    offer_request(make_req(CMD_QUERY, 32'h7FFFFFFE, 20'd0, 32'd0));
    offer_request(make_req(CMD_VALIDATE, 32'h7FFFFFFE, 20'd778, 32'd0));
    apply_settings(31'd1, 8'd255, 31'd1);
    offer_request(make_req(CMD_QUERY, 32'd5, 20'd0, 32'd0));
    offer_request(make_req(CMD_GENERATE, 32'd5, 20'd0, 32'd42));
    offer_request(make_req(CMD_VALIDATE, 32'd5, 20'd41, 32'd0));
    offer_request(make_req(CMD_VALIDATE, 32'd6, 20'd42, 32'd0));
    // With a threshold of zero the first miss already locks the gate.
    apply_settings(31'd300000, 8'd0, 31'd1);
    offer_request(make_req(CMD_GENERATE, 32'd10, 20'd0, 32'd5));
    offer_request(make_req(CMD_VALIDATE, 32'd10, 20'd6, 32'd0));
    offer_request(make_req(CMD_QUERY, 32'd11, 20'd0, 32'd0));
    settle();
  endtask

  task automatic test_random_sessions(input int unsigned count, input int unsigned span);
    repeat (count) offer_request(next_session_request(span));
    settle();
  endtask

  // The result side stops for a long stretch while items keep coming, so the
  // pipeline fills and the request side has to stall.
  task automatic test_output_backpressure(input int unsigned span);
    hold_order = 400;
    repeat (80) offer_request(next_session_request(span));
    settle();
  endtask

  initial begin
    rst                <= 1'b1;
    cfg_write          <= 1'b0;
    cfg_index          <= CFG_EXPIRY;
    cfg_data           <= 31'd0;
    req_ch.valid       <= 1'b0;
    req_ch.command     <= CMD_QUERY;
    req_ch.now_ms      <= 32'd0;
    req_ch.candidate   <= 20'd0;
    req_ch.random_word <= 32'd0;
    foreach (rc_tally[i]) rc_tally[i] = 0;
    forget_pin_state();
    m_expiry_ms = EXPIRY_RST;
    m_threshold = THRESHOLD_RST;
    m_lock_ms   = DURATION_RST;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idle(28, 80);
    test_directed_sequences();
    test_register_corners();
    apply_settings(31'd120, 8'd3, 31'd80);
    test_random_sessions(300, 100);
    apply_settings(31'h7FFFFFFF, 8'd255, 31'h7FFFFFFF);
    test_random_sessions(300, 32'd1 << 28);

    set_idle(80, 28);
    apply_settings(31'd1, 8'd1, 31'd1);
    test_random_sessions(300, 4);
    apply_settings(31'($urandom_range(1, 500)), 8'($urandom_range(1, 10)),
                   31'($urandom_range(1, 500)));
    test_random_sessions(300, 400);

    set_idle(0, 0);
    apply_settings(EXPIRY_RST, THRESHOLD_RST, DURATION_RST);
    test_random_sessions(300, 80000);
    test_output_backpressure(80000);
    apply_settings(31'($urandom_range(1, 3000)), 8'($urandom_range(1, 4)),
                   31'($urandom_range(1, 3000)));
    test_random_sessions(200, 2000);

    settle();
    repeat (8) @(posedge clk);
    $display("Checked %0d results for %0d requests across %0d register settings.",
             checked, sent, settings_applied);
    $display("Outcomes: %0d issued, %0d refused, %0d ok, %0d miss, %0d none,",
             rc_tally[RC_ISSUED], rc_tally[RC_REFUSED], rc_tally[RC_OK],
             rc_tally[RC_MISMATCH], rc_tally[RC_NO_ACTIVE],
             " %0d expired, %0d limited, %0d cleared, %0d status.",
             rc_tally[RC_EXPIRED], rc_tally[RC_RATE_LIMITED], rc_tally[RC_CLEARED],
             rc_tally[RC_STATUS]);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
